[rtl/core/mcfrr_pkg.sv]
// Package with the byte codes, element identifiers and register indexes of the frame responder.
package mcfrr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LenW    = 4;
  localparam int unsigned SeenW   = 2;
  localparam int unsigned BeatIdxW = 4;

  // Framing bytes.
  localparam logic [ByteW-1:0] StartByte  = 8'h7E;
  localparam logic [ByteW-1:0] CloseByte  = 8'h7F;
  localparam logic [ByteW-1:0] AddrByte   = 8'hFF;
  localparam logic [ByteW-1:0] CmdLenByte = 8'h84;
  localparam logic [ByteW-1:0] LenMask    = 8'h0F;

  // Element identifiers (high byte, low byte).
  localparam logic [WordW-1:0] IdTemp      = 16'h0606;
  localparam logic [WordW-1:0] IdPower     = 16'h17FF;
  localparam logic [WordW-1:0] IdGain      = 16'h18FF;
  localparam logic [WordW-1:0] IdFrequency = 16'h16FF;
  localparam logic [WordW-1:0] IdTempAlarm = 16'h0002;
  localparam logic [WordW-1:0] IdMute      = 16'h0601;

  // Reset values of the reported words.
  localparam logic [WordW-1:0] TempNormalRst = 16'd258;
  localparam logic [WordW-1:0] TempAlarmRst  = 16'd323;
  localparam logic [WordW-1:0] PowerRst      = 16'd300;
  localparam logic [WordW-1:0] GainRst       = 16'd520;
  localparam logic [WordW-1:0] FrequencyRst  = 16'd950;
  localparam logic [WordW-1:0] MuteRst       = 16'd1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_NORMAL = 3'd0,
    REG_TEMP_ALARM  = 3'd1,
    REG_POWER       = 3'd2,
    REG_GAIN        = 3'd3,
    REG_FREQUENCY   = 3'd4,
    REG_MUTE        = 3'd5
  } cfg_reg_e;

  // Positions of the beats within a reply frame.
  localparam logic [BeatIdxW-1:0] BeatStart   = 4'd0;
  localparam logic [BeatIdxW-1:0] BeatAddr    = 4'd1;
  localparam logic [BeatIdxW-1:0] BeatCmdLen  = 4'd2;
  localparam logic [BeatIdxW-1:0] BeatIdHigh  = 4'd3;
  localparam logic [BeatIdxW-1:0] BeatIdLow   = 4'd4;
  localparam logic [BeatIdxW-1:0] BeatValHigh = 4'd5;
  localparam logic [BeatIdxW-1:0] BeatValLow  = 4'd6;
  localparam logic [BeatIdxW-1:0] BeatCheck   = 4'd7;
  localparam logic [BeatIdxW-1:0] BeatClose   = 4'd8;

endpackage

[rtl/core/mc_frame_request_responder_top.sv]
// Top level of the monitoring frame request responder: deframer, lookup and reply buffer.

// Each received byte is one beat on the slave stream. The deframer hunts for the start
// byte 0x7E, skips the address byte, takes the data length from the low nibble of the
// command byte, keeps the first two data bytes as the element identifier and waits
// through the checksum and closing bytes. On the closing byte a known identifier loads a
// nine-byte reply (0x7E, 0xFF, 0x84, identifier, 16-bit value, check, 0x7F) into the
// reply buffer, which then presents one byte per beat on the master stream with tlast on
// the closing 0x7F. Unknown identifiers are consumed silently. The only input stall is a
// closing byte that arrives while the previous reply is still in the reply buffer and its
// closing beat does not leave in that same cycle, since the reply buffer holds one frame.
// This holds whether or not the new identifier is known.
// The temperature-alarm query answers the current alarm flag and then toggles it; the flag
// also picks which temperature word the temperature query reports. Configuration writes
// are always accepted and should be made while no request is in flight.
module mc_frame_request_responder_top
  import mcfrr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request byte stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // [7:0] rx_byte
  // Reply byte stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata,   // [7:0] reply_byte
  output logic               m_axis_tlast,   // reply_last
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ADDR   = 3'd1,
    PH_CMDLEN = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4,
    PH_CLOSE  = 3'd5
  } phase_e;

  // Configuration words.
  logic [WordW-1:0] temp_normal_q, temp_alarm_q, power_q, gain_q, frequency_q, mute_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_normal_q <= TempNormalRst;
      temp_alarm_q  <= TempAlarmRst;
      power_q       <= PowerRst;
      gain_q        <= GainRst;
      frequency_q   <= FrequencyRst;
      mute_q        <= MuteRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TEMP_NORMAL: temp_normal_q <= cfg_data_i;
        REG_TEMP_ALARM:  temp_alarm_q  <= cfg_data_i;
        REG_POWER:       power_q       <= cfg_data_i;
        REG_GAIN:        gain_q        <= cfg_data_i;
        REG_FREQUENCY:   frequency_q   <= cfg_data_i;
        REG_MUTE:        mute_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Deframer state.
  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  data_left_q, data_left_d;
  logic [SeenW-1:0] data_seen_q, data_seen_d;
  logic [ByteW-1:0] id_high_q, id_high_d, id_low_q, id_low_d;
  logic             alarm_q, alarm_d;

  // Reply buffer.
  logic                busy_q, busy_d;
  logic [BeatIdxW-1:0] beat_q, beat_d;
  logic [ByteW-1:0]    rep_id_high_q, rep_id_low_q, rep_check_q;
  logic [WordW-1:0]    rep_value_q;

  logic             in_fire, out_fire, out_done, load;
  logic             id_known;
  logic [WordW-1:0] id_word, value;
  logic [ByteW-1:0] check;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign out_done = out_fire && m_axis_tlast;

  // A closing byte may only be taken when the buffer is free or drains this cycle.
  assign s_axis_tready = !(phase_q == PH_CLOSE && busy_q && !out_done);

  // Identifier lookup.
  assign id_word = {id_high_q, id_low_q};

  always_comb begin
    id_known = 1'b1;
    value    = '0;
    if (id_word == IdTemp) begin
      value = alarm_q ? temp_alarm_q : temp_normal_q;
    end else if (id_word == IdPower) begin
      value = power_q;
    end else if (id_word == IdGain) begin
      value = gain_q;
    end else if (id_word == IdFrequency) begin
      value = frequency_q;
    end else if (id_word == IdTempAlarm) begin
      value = {{(WordW-1){1'b0}}, alarm_q};
    end else if (id_word == IdMute) begin
      value = mute_q;
    end else begin
      id_known = 1'b0;
    end
  end

  assign check = ~(AddrByte ^ CmdLenByte ^ id_high_q ^ id_low_q
                   ^ value[WordW-1:ByteW] ^ value[ByteW-1:0]);

  assign load = in_fire && (phase_q == PH_CLOSE) && id_known;

  // Next state of the deframer for an accepted byte.
  always_comb begin
    phase_d     = phase_q;
    data_left_d = data_left_q;
    data_seen_d = data_seen_q;
    id_high_d   = id_high_q;
    id_low_d    = id_low_q;
    alarm_d     = alarm_q;
    if (in_fire) begin
      case (phase_q)
        PH_ADDR: phase_d = PH_CMDLEN;
        PH_CMDLEN: begin
          data_left_d = LenW'(s_axis_tdata & LenMask);
          phase_d     = (data_left_d != '0) ? PH_DATA : PH_CHECK;
        end
        PH_DATA: begin
          if (data_seen_q == 2'd0) begin
            id_high_d   = s_axis_tdata;
            data_seen_d = 2'd1;
          end else if (data_seen_q == 2'd1) begin
            id_low_d    = s_axis_tdata;
            data_seen_d = 2'd2;
          end
          data_left_d = data_left_q - 1'b1;
          if (data_left_d == '0) phase_d = PH_CHECK;
        end
        PH_CHECK: phase_d = PH_CLOSE;
        PH_CLOSE: begin
          phase_d = PH_HUNT;
          if (id_word == IdTempAlarm) alarm_d = !alarm_q;
        end
        default: begin
          phase_d = PH_HUNT;
          if (s_axis_tdata == StartByte) begin
            phase_d     = PH_ADDR;
            data_left_d = '0;
            data_seen_d = '0;
            id_high_d   = '0;
            id_low_d    = '0;
          end
        end
      endcase
    end
  end

  // Reply buffer control.
  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    if (out_fire) begin
      if (out_done) busy_d = 1'b0;
      beat_d = beat_q + 1'b1;
    end
    if (load) begin
      busy_d = 1'b1;
      beat_d = BeatStart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      data_left_q <= '0;
      data_seen_q <= '0;
      id_high_q   <= '0;
      id_low_q    <= '0;
      alarm_q     <= 1'b0;
      busy_q      <= 1'b0;
      beat_q      <= BeatStart;
    end else begin
      phase_q     <= phase_d;
      data_left_q <= data_left_d;
      data_seen_q <= data_seen_d;
      id_high_q   <= id_high_d;
      id_low_q    <= id_low_d;
      alarm_q     <= alarm_d;
      busy_q      <= busy_d;
      beat_q      <= beat_d;
    end
  end

  // Reply payload, captured once per frame.
  always_ff @(posedge clk_i) begin
    if (load) begin
      rep_id_high_q <= id_high_q;
      rep_id_low_q  <= id_low_q;
      rep_value_q   <= value;
      rep_check_q   <= check;
    end
  end

  // Byte select for the current beat.
  always_comb begin
    case (beat_q)
      BeatStart:   m_axis_tdata = StartByte;
      BeatAddr:    m_axis_tdata = AddrByte;
      BeatCmdLen:  m_axis_tdata = CmdLenByte;
      BeatIdHigh:  m_axis_tdata = rep_id_high_q;
      BeatIdLow:   m_axis_tdata = rep_id_low_q;
      BeatValHigh: m_axis_tdata = rep_value_q[WordW-1:ByteW];
      BeatValLow:  m_axis_tdata = rep_value_q[ByteW-1:0];
      BeatCheck:   m_axis_tdata = rep_check_q;
      BeatClose:   m_axis_tdata = CloseByte;
      default:     m_axis_tdata = CloseByte;
    endcase
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = (beat_q == BeatClose);

  // The input stalls only on a closing byte while a reply is still draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (phase_q == PH_CLOSE) && busy_q)
    else $error("input stalled outside a pending reply");

  // A new reply never overwrites one that still has beats to deliver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !busy_q || out_done)
    else $error("reply buffer overrun");

  // After the closing beat leaves, the stream goes quiet unless a new reply was loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done && !load |=> !m_axis_tvalid)
    else $error("reply continues past its closing beat");

  // The data phase always has at least one byte left to take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (data_left_q != '0))
    else $error("data phase with no bytes left");

endmodule

[bench/tb_mc_frame_request_responder_top.sv]
// Self-checking testbench of the monitoring frame request responder with its reply predictor.
module tb_mc_frame_request_responder_top;
  import mcfrr_pkg::*;

  localparam int unsigned StallLimit  = 2000;  // cycles without any handshake before giving up
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned SettleCycles = 20;
  // Register indexes beyond the last register; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHigh = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } reply_beat_t;

  typedef enum logic [2:0] {
    SEEK_START, GET_ADDR, GET_CMDLEN, GET_DATA, GET_CHECKSUM, GET_CLOSE
  } rx_phase_e;

  // Tracks the deframer and the reply words, and keeps the reply beats still owed.
  class reply_predictor;
    logic [WordW-1:0] temp_normal, temp_alarm, power, gain, frequency, mute;
    rx_phase_e        phase;
    logic [LenW-1:0]  data_left;
    logic [SeenW-1:0] data_seen;
    logic [ByteW-1:0] id_high, id_low;
    logic             alarm_on;
    reply_beat_t      owed_beats[$];
    int unsigned      mismatches;

    function new();
      temp_normal = TempNormalRst;
      temp_alarm  = TempAlarmRst;
      power       = PowerRst;
      gain        = GainRst;
      frequency   = FrequencyRst;
      mute        = MuteRst;
      phase       = SEEK_START;
      data_left   = '0;
      data_seen   = '0;
      id_high     = '0;
      id_low      = '0;
      alarm_on    = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] value);
      case (idx)
        REG_TEMP_NORMAL: temp_normal = value;
        REG_TEMP_ALARM:  temp_alarm  = value;
        REG_POWER:       power       = value;
        REG_GAIN:        gain        = value;
        REG_FREQUENCY:   frequency   = value;
        REG_MUTE:        mute        = value;
        default: ;
      endcase
    endfunction

    // Looks up the identifier and queues the nine reply beats if it is a known one.
    function void answer_request();
      logic [WordW-1:0] value;
      logic [ByteW-1:0] frame [9];
      case ({id_high, id_low})
        IdTemp:      value = alarm_on ? temp_alarm : temp_normal;
        IdPower:     value = power;
        IdGain:      value = gain;
        IdFrequency: value = frequency;
        IdMute:      value = mute;
        IdTempAlarm: begin
          value    = {{(WordW-1){1'b0}}, alarm_on};
          alarm_on = ~alarm_on;
        end
        default: return;
      endcase
      frame[BeatStart]   = StartByte;
      frame[BeatAddr]    = AddrByte;
      frame[BeatCmdLen]  = CmdLenByte;
      frame[BeatIdHigh]  = id_high;
      frame[BeatIdLow]   = id_low;
      frame[BeatValHigh] = value[WordW-1:ByteW];
      frame[BeatValLow]  = value[ByteW-1:0];
      frame[BeatCheck]   = ~(AddrByte ^ CmdLenByte ^ id_high ^ id_low ^
                             value[WordW-1:ByteW] ^ value[ByteW-1:0]);
      frame[BeatClose]   = CloseByte;
      for (int k = 0; k < 9; k++)
        owed_beats.push_back('{data: frame[k], last: (k == int'(BeatClose))});
    endfunction

    function void take_rx_byte(logic [ByteW-1:0] b);
      case (phase)
        GET_ADDR:   phase = GET_CMDLEN;
        GET_CMDLEN: begin
          data_left = LenW'(b & LenMask);
          phase     = (data_left != '0) ? GET_DATA : GET_CHECKSUM;
        end
        GET_DATA: begin
          // Only the first two data bytes form the identifier; the rest are skipped.
          if (data_seen == 2'd0) begin
            id_high   = b;
            data_seen = 2'd1;
          end else if (data_seen == 2'd1) begin
            id_low    = b;
            data_seen = 2'd2;
          end
          data_left = data_left - 1'b1;
          if (data_left == '0) phase = GET_CHECKSUM;
        end
        GET_CHECKSUM: phase = GET_CLOSE;
        GET_CLOSE: begin
          phase = SEEK_START;
          answer_request();
        end
        default: begin
          phase = SEEK_START;
          if (b == StartByte) begin
            phase     = GET_ADDR;
            data_left = '0;
            data_seen = '0;
            id_high   = '0;
            id_low    = '0;
          end
        end
      endcase
    endfunction

    function void check_reply_beat(logic [ByteW-1:0] data, logic last);
      reply_beat_t want;
      if (owed_beats.size() == 0) begin
        $display("%0t: reply beat %02h last %0b arrived with none expected", $time, data, last);
        mismatches++;
        return;
      end
      want = owed_beats.pop_front();
      if (data !== want.data) begin
        $display("%0t: reply byte expected %02h actual %02h", $time, want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: reply last expected %0b actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [ByteW-1:0]   m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [WordW-1:0]   cfg_data_i;

  reply_predictor book;
  bit             sender_gaps;
  bit             receiver_stalls;
  int unsigned    hold_left;
  int unsigned    sent_bytes;
  int unsigned    quiet_cycles;
  logic [WordW-1:0] known_ids [6];

  mc_frame_request_responder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, or a counted hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = !(receiver_stalls && $urandom_range(99) < 33);
      end
    end
  end

  // Monitor: every handshake is sampled at the rising edge; outputs are checked before
  // the same edge's inputs are predicted. A long run without any handshake ends the test.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) book.check_reply_beat(m_axis_tdata, m_axis_tlast);
      if (cfg_valid_i && cfg_ready_o) book.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) book.take_rx_byte(s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (cfg_valid_i && cfg_ready_o) ||
          (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while (sender_gaps && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_request(input logic [WordW-1:0] ident, input int unsigned len);
    send_byte(StartByte);
    send_byte(ByteW'($urandom));                 // address, ignored
    send_byte({4'($urandom), LenW'(len)});       // command nibble is random
    for (int k = 0; k < int'(len); k++)
      send_byte(k == 0 ? ident[WordW-1:ByteW] : k == 1 ? ident[ByteW-1:0] : ByteW'($urandom));
    send_byte(ByteW'($urandom));                 // checksum, not checked
    send_byte(ByteW'($urandom));                 // closing byte, not checked
  endtask

  // Mostly well-formed queries for known elements, plus unknown ones, line noise and
  // requests cut short by a following start byte.
  task automatic run_random(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    goal = sent_bytes + n_bytes;
    while (sent_bytes < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        len  = (pick < 60) ? 2 : (pick < 85) ? $urandom_range(6, 3) :
               (pick < 95) ? $urandom_range(14, 7) : 15;
        send_request(known_ids[$urandom_range(5)], len);
      end else if (pick < 80) begin
        send_request(WordW'($urandom), $urandom_range(15));
      end else if (pick < 90) begin
        repeat ($urandom_range(4, 1)) send_byte(ByteW'($urandom));
      end else begin
        send_byte(StartByte);
        repeat ($urandom_range(3, 1)) send_byte(ByteW'($urandom));
      end
    end
  endtask

  task automatic drain_replies();
    stop_sending();
    while (book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic program_regs(input logic [WordW-1:0] tn, ta, pw, gn, fq, mu);
    cfg_write(REG_TEMP_NORMAL, tn);
    cfg_write(REG_TEMP_ALARM, ta);
    cfg_write(REG_POWER, pw);
    cfg_write(REG_GAIN, gn);
    cfg_write(REG_FREQUENCY, fq);
    cfg_write(REG_MUTE, mu);
  endtask

  initial begin
    book            = new();
    known_ids       = '{IdTemp, IdPower, IdGain, IdFrequency, IdTempAlarm, IdMute};
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_left       = 0;
    sent_bytes      = 0;
    quiet_cycles    = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with reset register values: noise while hunting, a temperature query,
    // the alarm query, a request without data and one whose identifier lacks its low byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_request(IdTemp, 2);
    send_request(IdTempAlarm, 2);
    send_request(IdTemp, 0);
    send_request(IdTemp, 1);
    drain_replies();

    // All words at their maximum; a long receiver hold-off fills the reply buffer.
    program_regs('1, '1, '1, '1, '1, '1);
    cfg_write(RegSpareLow, WordW'($urandom));
    run_random(20);
    hold_left = HoldCycles;
    run_random(80);
    drain_replies();

    // All words zero, no idling on either side, and one pause until every reply is out.
    program_regs('0, '0, '0, '0, '0, '0);
    cfg_write(RegSpareHigh, WordW'($urandom));
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_random(50);
    drain_replies();
    run_random(50);
    drain_replies();

    // Random words with idling back on.
    program_regs(WordW'($urandom), WordW'($urandom), WordW'($urandom),
                 WordW'($urandom), WordW'($urandom), WordW'($urandom));
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    run_random(90);
    drain_replies();
    repeat (SettleCycles) @(posedge clk_i);

    if (book.mismatches == 0 && book.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
